@@ design/spawq_pkg.sv @@
// shared constants, codes and control and status structs of the slot pool allocator
`default_nettype none
package spawq_pkg;

   localparam int POOL_SLOTS    = 16;
   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_BITS       = 8;
   localparam int SLOT_BITS     = $clog2(POOL_SLOTS);
   localparam int SLOT_CNT_BITS = 5;
   localparam int QIDX_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int KIND_BITS     = 2;
   localparam int STATUS_BITS   = 3;
   localparam int SLOT_OUT_BITS = 4;
   localparam int UNIT_OUT_BITS = 8;
   localparam logic [SLOT_CNT_BITS-1:0] SLOTS_RESET = SLOT_CNT_BITS'(16);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_REQUEST  = 2'd0,
      KIND_RETURN   = 2'd1,
      KIND_DISPATCH = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_GRANTED    = 3'd0,
      ST_QUEUED     = 3'd1,
      ST_DROPPED    = 3'd2,
      ST_FREED      = 3'd3,
      ST_NOT_OWNED  = 3'd4,
      ST_DISPATCHED = 3'd5,
      ST_NONE       = 3'd6,
      ST_CLEARED    = 3'd7
   } status_type;

   typedef struct packed {
      logic               grant;
      logic               release_slot;
      logic               clear_all;
      logic [ID_BITS-1:0] id;
   } slot_ctrl_type;

   typedef struct packed {
      logic                 free_any;
      logic [SLOT_BITS-1:0] free_idx;
      logic                 own_any;
      logic [SLOT_BITS-1:0] own_idx;
   } slot_stat_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               clear_all;
      logic [ID_BITS-1:0] push_id;
   } queue_ctrl_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [ID_BITS-1:0] head_id;
   } queue_stat_type;

endpackage
`default_nettype wire

@@ design/spawq_if.sv @@
// handshake interfaces of the request, response and register write channels
`default_nettype none
interface spawq_req_if;
   logic                                valid;
   logic                                ready;
   logic [spawq_pkg::KIND_BITS-1:0]     req_type;
   logic [spawq_pkg::ID_BITS-1:0]       unit_id;
   modport source (output valid, output req_type, output unit_id, input ready);
   modport sink   (input valid, input req_type, input unit_id, output ready);
endinterface

interface spawq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [spawq_pkg::STATUS_BITS-1:0]    status;
   logic [spawq_pkg::SLOT_OUT_BITS-1:0]  slot_index;
   logic [spawq_pkg::UNIT_OUT_BITS-1:0]  dispatch_unit;
   modport source (output valid, output status, output slot_index, output dispatch_unit,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input dispatch_unit,
                   output ready);
endinterface

interface spawq_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [spawq_pkg::SLOT_CNT_BITS-1:0]  slots_in_use;
   modport source (output valid, output slots_in_use, input ready);
   modport sink   (input valid, input slots_in_use, output ready);
endinterface
`default_nettype wire

@@ design/slot_pool_allocator_wait_queue.sv @@
// top level of the slot pool allocator with its wait queue
//
//  channel    dir  handshake      payload
//  req_chan   in   valid/ready    req_type[1:0], unit_id[7:0]
//  rsp_chan   out  valid/ready    status[2:0], slot_index[3:0], dispatch_unit[7:0]
//  csr_chan   in   valid/ready    slots_in_use[4:0]
//
//  an item is latched in the input register, decoded combinationally against the
//  slot and queue state and lands in the result register, which drives the response;
//  one item per cycle sustained while the response side is ready
//  synchronous active-high reset frees all slots, empties the queue and sets
//  slots_in_use to 16; owners and queue entries are left as they are
//  a stalled response holds the input register, which then blocks the request side
`default_nettype none
module slot_pool_allocator_wait_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   spawq_req_if.sink        req_chan,
   spawq_rsp_if.source      rsp_chan,
   spawq_csr_if.sink        csr_chan
);

   // input register
   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   logic [spawq_pkg::KIND_BITS-1:0]      in_kind_ff;
   logic [spawq_pkg::ID_BITS-1:0]        in_id_ff;

   // result register
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   spawq_pkg::status_type                rsp_status_ff;
   spawq_pkg::status_type                rsp_status_in;
   logic [spawq_pkg::SLOT_OUT_BITS-1:0]  rsp_slot_ff;
   logic [spawq_pkg::SLOT_OUT_BITS-1:0]  rsp_slot_in;
   logic [spawq_pkg::UNIT_OUT_BITS-1:0]  rsp_unit_ff;
   logic [spawq_pkg::UNIT_OUT_BITS-1:0]  rsp_unit_in;

   logic [spawq_pkg::SLOT_CNT_BITS-1:0]  slots_ff;

   logic                                 process;
   spawq_pkg::slot_ctrl_type             slot_ctrl;
   spawq_pkg::slot_stat_type             slot_stat;
   spawq_pkg::queue_ctrl_type            queue_ctrl;
   spawq_pkg::queue_stat_type            queue_stat;

   // the held item moves on when the result register is empty or draining
   assign process        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || process;
   assign csr_chan.ready = 1'b1;

   spawq_slots u_slots (
      .clock        (clock),
      .reset        (reset),
      .slots_in_use (slots_ff),
      .ctrl         (slot_ctrl),
      .stat         (slot_stat)
   );

   spawq_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (queue_ctrl),
      .stat  (queue_stat)
   );

   // decode of the held item against current slot and queue state
   always_comb begin
      slot_ctrl         = '0;
      slot_ctrl.id      = in_id_ff;
      queue_ctrl        = '0;
      queue_ctrl.push_id = in_id_ff;
      rsp_status_in     = spawq_pkg::ST_NONE;
      rsp_slot_in       = '0;
      rsp_unit_in       = '0;
      case (spawq_pkg::kind_type'(in_kind_ff))
         spawq_pkg::KIND_REQUEST: begin
            if (slot_stat.free_any) begin
               slot_ctrl.grant = process;
               rsp_status_in   = spawq_pkg::ST_GRANTED;
               rsp_slot_in     = spawq_pkg::SLOT_OUT_BITS'(slot_stat.free_idx);
            end else if (!queue_stat.full) begin
               queue_ctrl.push = process;
               rsp_status_in   = spawq_pkg::ST_QUEUED;
            end else begin
               rsp_status_in   = spawq_pkg::ST_DROPPED;
            end
         end
         spawq_pkg::KIND_RETURN: begin
            if (slot_stat.own_any) begin
               slot_ctrl.release_slot = process;
               rsp_status_in          = spawq_pkg::ST_FREED;
               rsp_slot_in            = spawq_pkg::SLOT_OUT_BITS'(slot_stat.own_idx);
            end else begin
               rsp_status_in          = spawq_pkg::ST_NOT_OWNED;
            end
         end
         spawq_pkg::KIND_DISPATCH: begin
            // pops only, no slot is taken
            if (slot_stat.free_any && !queue_stat.empty) begin
               queue_ctrl.pop = process;
               rsp_status_in  = spawq_pkg::ST_DISPATCHED;
               rsp_unit_in    = spawq_pkg::UNIT_OUT_BITS'(queue_stat.head_id);
            end else begin
               rsp_status_in  = spawq_pkg::ST_NONE;
            end
         end
         spawq_pkg::KIND_CLEAR: begin
            slot_ctrl.clear_all  = process;
            queue_ctrl.clear_all = process;
            rsp_status_in        = spawq_pkg::ST_CLEARED;
         end
         default: begin
            rsp_status_in = spawq_pkg::ST_NONE;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slots_ff     <= spawq_pkg::SLOTS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            slots_ff <= csr_chan.slots_in_use;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_kind_ff <= req_chan.req_type;
         in_id_ff   <= req_chan.unit_id;
      end
      if (process) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_unit_ff   <= rsp_unit_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.slot_index    = rsp_slot_ff;
   assign rsp_chan.dispatch_unit = rsp_unit_ff;

endmodule
`default_nettype wire

@@ design/spawq_slots.sv @@
// slot busy bits and owners with lowest-free and lowest-owned priority encoders
`default_nettype none
module spawq_slots (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [spawq_pkg::SLOT_CNT_BITS-1:0] slots_in_use,
   input  wire spawq_pkg::slot_ctrl_type            ctrl,
   output spawq_pkg::slot_stat_type                 stat
);

   logic [spawq_pkg::POOL_SLOTS-1:0] busy_ff;
   logic [spawq_pkg::POOL_SLOTS-1:0] busy_in;
   logic [spawq_pkg::ID_BITS-1:0]    owner_ff [spawq_pkg::POOL_SLOTS];
   logic [spawq_pkg::POOL_SLOTS-1:0] free_mask;
   logic [spawq_pkg::POOL_SLOTS-1:0] own_mask;

   always_comb begin
      for (int i = 0; i < spawq_pkg::POOL_SLOTS; i++) begin
         free_mask[i] = !busy_ff[i] &&
                        (spawq_pkg::SLOT_CNT_BITS'(i) < slots_in_use);
         own_mask[i]  = busy_ff[i] && (owner_ff[i] == ctrl.id);
      end
   end

   // lowest set bit wins
   always_comb begin
      stat = '0;
      stat.free_any = |free_mask;
      stat.own_any  = |own_mask;
      for (int i = spawq_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            stat.free_idx = spawq_pkg::SLOT_BITS'(i);
         end
         if (own_mask[i]) begin
            stat.own_idx = spawq_pkg::SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (ctrl.clear_all) begin
         busy_in = '0;
      end else if (ctrl.grant) begin
         busy_in[stat.free_idx] = 1'b1;
      end else if (ctrl.release_slot) begin
         busy_in[stat.own_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.grant && !ctrl.clear_all) begin
         owner_ff[stat.free_idx] <= ctrl.id;
      end
   end

endmodule
`default_nettype wire

@@ design/spawq_queue.sv @@
// circular wait queue of requester ids
`default_nettype none
module spawq_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire spawq_pkg::queue_ctrl_type ctrl,
   output spawq_pkg::queue_stat_type      stat
);

   logic [spawq_pkg::ID_BITS-1:0]   entry_ff [spawq_pkg::QUEUE_DEPTH];
   logic [spawq_pkg::QIDX_BITS-1:0] head_ff;
   logic [spawq_pkg::QIDX_BITS-1:0] head_in;
   logic [spawq_pkg::QCNT_BITS-1:0] count_ff;
   logic [spawq_pkg::QCNT_BITS-1:0] count_in;
   logic [spawq_pkg::QCNT_BITS:0]   tail_sum;
   logic [spawq_pkg::QIDX_BITS-1:0] tail_idx;

   // head plus count, wrapped once
   always_comb begin
      tail_sum = (spawq_pkg::QCNT_BITS + 1)'(head_ff) + (spawq_pkg::QCNT_BITS + 1)'(count_ff);
      if (tail_sum >= (spawq_pkg::QCNT_BITS + 1)'(spawq_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (spawq_pkg::QCNT_BITS + 1)'(spawq_pkg::QUEUE_DEPTH);
      end
      tail_idx = tail_sum[spawq_pkg::QIDX_BITS-1:0];
   end

   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == spawq_pkg::QCNT_BITS'(spawq_pkg::QUEUE_DEPTH));
   assign stat.head_id = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.clear_all) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctrl.push) begin
         count_in = count_ff + spawq_pkg::QCNT_BITS'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - spawq_pkg::QCNT_BITS'(1);
         if (head_ff == spawq_pkg::QIDX_BITS'(spawq_pkg::QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + spawq_pkg::QIDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear_all) begin
         entry_ff[tail_idx] <= ctrl.push_id;
      end
   end

endmodule
`default_nettype wire
